/* rtl/gpm_pkg.sv */
// ----------------------------------------------------------------------------
// gpm_pkg
// shared constants, request codes and control types of the p-median site
// selector
// ----------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

  // default sizing of the stores and the grid
  localparam int MAX_HOUSES_DEF = 128;
  localparam int MAX_SITES_DEF  = 16;
  localparam int COORD_BITS_DEF = 6;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int FIELD_W = 6;
  localparam int K_W     = 5;
  localparam int TOTAL_W = 14;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [K_W-1:0]     K_RESET   = 5'd1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ADD_HOUSE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_SITE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd3;

  // register port
  localparam int   APB_AW    = 3;
  localparam int   APB_DW    = 32;
  localparam logic REG_K_IDX = 1'b0;

  // control that travels with one house/site update
  typedef struct packed {
    logic valid;       // update slot in use
    logic first;       // first chosen site of the subset
    logic last;        // last chosen site of the subset
    logic subset_end;  // last house of the last site: subset total complete
  } issue_ctl_t;

endpackage

`default_nettype wire

/* rtl/gpm_seq.sv */
// ----------------------------------------------------------------------------
// gpm_seq
// site store and update sequencer: walks the site subsets in ascending
// combination order and, per chosen site, every loaded house
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_seq #(
  parameter int MAX_HOUSES = gpm_pkg::MAX_HOUSES_DEF,
  parameter int MAX_SITES  = gpm_pkg::MAX_SITES_DEF,
  parameter int COORD_BITS = gpm_pkg::COORD_BITS_DEF,
  localparam int HIDX_W = (MAX_HOUSES > 1) ? $clog2(MAX_HOUSES) : 1,
  localparam int HCNT_W = $clog2(MAX_HOUSES + 1),
  localparam int SCNT_W = $clog2(MAX_SITES + 1),
  localparam int PT_W   = 2 * COORD_BITS
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [gpm_pkg::K_W-1:0]     k,
  input  wire [HCNT_W-1:0]           house_count,
  input  wire [SCNT_W-1:0]           site_count,
  input  wire                        site_we,
  input  wire [PT_W-1:0]             site_wdata,
  output gpm_pkg::issue_ctl_t        iss,
  output logic [HIDX_W-1:0]          iss_addr,
  output logic [PT_W-1:0]            iss_site,
  output logic                       busy
);
  import gpm_pkg::*;

  localparam int SIDX_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int MASK_W = MAX_SITES + 1;
  localparam int SH_W   = $clog2(MASK_W);

  localparam logic SQ_IDLE = 1'b0;
  localparam logic SQ_RUN  = 1'b1;

  logic [PT_W-1:0]      site_mem [MAX_SITES];

  logic                 state_r, state_nxt;
  logic [MASK_W-1:0]    x_r, x_nxt;
  logic [MAX_SITES-1:0] rem_r, rem_nxt;
  logic [HIDX_W-1:0]    h_r, h_nxt;
  logic                 first_r, first_nxt;

  logic [MASK_W-1:0]    init_mask;
  logic [MASK_W-1:0]    below_cnt;
  logic [MASK_W-1:0]    low, r_sum, ones, next_comb;
  logic [SH_W-1:0]      low_idx;
  logic [SIDX_W-1:0]    cur_idx;
  logic                 rem_last, h_last, next_ok;

  // site store
  always_ff @(posedge clk) begin
    if (site_we) begin
      site_mem[site_count[SIDX_W-1:0]] <= site_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      init_mask[i] = (i < int'(k));
      below_cnt[i] = (i < int'(site_count));
    end
  end

  // lowest chosen site still to visit in this subset
  always_comb begin
    cur_idx = '0;
    for (int i = MAX_SITES - 1; i >= 0; i--) begin
      if (rem_r[i]) cur_idx = SIDX_W'(i);
    end
  end

  // next combination with the same number of ones
  always_comb begin
    low     = x_r & (~x_r + 1'b1);
    r_sum   = x_r + low;
    low_idx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (low[i]) low_idx = SH_W'(i);
    end
    ones      = ((r_sum ^ x_r) >> 2) >> low_idx;
    next_comb = r_sum | ones;
    next_ok   = ~|(next_comb & ~below_cnt);
  end

  assign rem_last = ((rem_r & (rem_r - 1'b1)) == '0);
  assign h_last   = ((HCNT_W'(h_r) + 1'b1) == house_count);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    h_nxt     = h_r;
    first_nxt = first_r;
    case (state_r)
      SQ_IDLE: begin
        if (start) begin
          state_nxt = SQ_RUN;
          x_nxt     = init_mask;
          rem_nxt   = init_mask[MAX_SITES-1:0];
          h_nxt     = '0;
          first_nxt = 1'b1;
        end
      end
      SQ_RUN: begin
        if (h_last) begin
          h_nxt = '0;
          if (rem_last) begin
            if (next_ok) begin
              x_nxt     = next_comb;
              rem_nxt   = next_comb[MAX_SITES-1:0];
              first_nxt = 1'b1;
            end else begin
              state_nxt = SQ_IDLE;
            end
          end else begin
            rem_nxt   = rem_r & (rem_r - 1'b1);
            first_nxt = 1'b0;
          end
        end else begin
          h_nxt = h_r + 1'b1;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r     <= x_nxt;
    rem_r   <= rem_nxt;
    h_r     <= h_nxt;
    first_r <= first_nxt;
  end

  assign iss.valid      = (state_r == SQ_RUN);
  assign iss.first      = first_r;
  assign iss.last       = rem_last;
  assign iss.subset_end = rem_last && h_last;
  assign iss_addr       = h_r;
  assign iss_site       = site_mem[cur_idx];
  assign busy           = (state_r == SQ_RUN);

endmodule

`default_nettype wire

/* rtl/gpm_eng.sv */
// ----------------------------------------------------------------------------
// gpm_eng
// house store and nearest-distance memory: read, take the minimum against
// the current site, write back, and fold subset totals into the best
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_eng #(
  parameter int MAX_HOUSES = gpm_pkg::MAX_HOUSES_DEF,
  parameter int COORD_BITS = gpm_pkg::COORD_BITS_DEF,
  localparam int HIDX_W = (MAX_HOUSES > 1) ? $clog2(MAX_HOUSES) : 1,
  localparam int PT_W   = 2 * COORD_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          clear_best,
  input  wire                          house_we,
  input  wire [HIDX_W-1:0]             house_waddr,
  input  wire [PT_W-1:0]               house_wdata,
  input  gpm_pkg::issue_ctl_t          iss,
  input  wire [HIDX_W-1:0]             iss_addr,
  input  wire [PT_W-1:0]               iss_site,
  output logic                         busy,
  output logic [gpm_pkg::TOTAL_W-1:0]  best
);
  import gpm_pkg::*;

  localparam int DIST_W = COORD_BITS + 1;

  logic [PT_W-1:0]    house_mem [MAX_HOUSES];
  logic [DIST_W-1:0]  near_mem  [MAX_HOUSES];

  logic [PT_W-1:0]    house_rd_r;
  logic [DIST_W-1:0]  near_rd_r;

  issue_ctl_t         b_ctl_r;
  logic [HIDX_W-1:0]  b_addr_r;
  logic [PT_W-1:0]    b_site_r;
  logic               fwd_r;
  logic [DIST_W-1:0]  fwd_data_r;

  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] best_r, best_nxt;

  logic [COORD_BITS-1:0] hr, hc, sr, sc, dr, dc;
  logic [DIST_W-1:0]     cand_d, old_d, m;
  logic [TOTAL_W:0]      sum;
  logic [TOTAL_W-1:0]    sat;
  logic                  fwd_hit;

  // house store: written on loads, read one house per cycle during compute
  always_ff @(posedge clk) begin
    if (house_we) begin
      house_mem[house_waddr] <= house_wdata;
    end
    house_rd_r <= house_mem[iss_addr];
  end

  // nearest distance so far, per house
  always_ff @(posedge clk) begin
    if (b_ctl_r.valid) begin
      near_mem[b_addr_r] <= m;
    end
    near_rd_r <= near_mem[iss_addr];
  end

  // same house read right behind its own write-back (single house)
  assign fwd_hit = iss.valid && b_ctl_r.valid && (iss_addr == b_addr_r);

  always_comb begin
    hr     = house_rd_r[PT_W-1:COORD_BITS];
    hc     = house_rd_r[COORD_BITS-1:0];
    sr     = b_site_r[PT_W-1:COORD_BITS];
    sc     = b_site_r[COORD_BITS-1:0];
    dr     = (hr > sr) ? (hr - sr) : (sr - hr);
    dc     = (hc > sc) ? (hc - sc) : (sc - hc);
    cand_d = DIST_W'(dr) + DIST_W'(dc);
    old_d  = fwd_r ? fwd_data_r : near_rd_r;
    m      = (b_ctl_r.first || (cand_d < old_d)) ? cand_d : old_d;
    sum    = (TOTAL_W + 1)'(total_r) + (TOTAL_W + 1)'(m);
    sat    = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  end

  always_comb begin
    total_nxt = total_r;
    best_nxt  = best_r;
    if (clear_best) begin
      total_nxt = '0;
      best_nxt  = TOTAL_MAX;
    end else if (b_ctl_r.valid && b_ctl_r.last) begin
      if (b_ctl_r.subset_end) begin
        total_nxt = '0;
        if (sat < best_r) best_nxt = sat;
      end else begin
        total_nxt = sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
      fwd_r   <= 1'b0;
      total_r <= '0;
      best_r  <= TOTAL_MAX;
    end else begin
      b_ctl_r <= iss;
      fwd_r   <= fwd_hit;
      total_r <= total_nxt;
      best_r  <= best_nxt;
    end
    b_addr_r   <= iss_addr;
    b_site_r   <= iss_site;
    fwd_data_r <= m;
  end

  assign busy = b_ctl_r.valid;
  assign best = best_r;

endmodule

`default_nettype wire

/* rtl/grid_p_median_site_selector_unit.sv */
// ----------------------------------------------------------------------------
// grid_p_median_site_selector_unit
// p-median site selection on a grid with manhattan distance
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready): one request per item; mode picks add house,
//   add site, compute or clear. row/col are used for adds only.
//   out channel (out_valid/out_ready): one result per compute request carrying
//   best_total, error and the sticky overflow flag. loads and clears give none.
//   register port: sites_to_choose at byte address 0, write only while idle.
// timing
//   add and clear requests are taken back to back.
//   a compute result is registered once every chosen site of every subset
//   has passed every house once through the read-modify-write of the
//   nearest-distance memory, one house per cycle.
//   an error compute (too few sites, no houses, k of zero) skips the search.
//   in_ready is low from the compute request until its result is registered.
// reset
//   clears counts, overflow flag and output valid, and loads sites_to_choose
//   with 1. the stores need no clearing pass; only written entries are read.
// stalls
//   a held result does not block add or clear requests; a following compute
//   waits at its end until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_p_median_site_selector_unit #(
  parameter int MAX_HOUSES = gpm_pkg::MAX_HOUSES_DEF,
  parameter int MAX_SITES  = gpm_pkg::MAX_SITES_DEF,
  parameter int COORD_BITS = gpm_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // request channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [gpm_pkg::MODE_W-1:0]    in_mode,
  input  wire [gpm_pkg::FIELD_W-1:0]   in_row,
  input  wire [gpm_pkg::FIELD_W-1:0]   in_col,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [gpm_pkg::TOTAL_W-1:0]  out_best_total,
  output logic                         out_error,
  output logic                         out_overflow,
  // register port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [gpm_pkg::APB_AW-1:0]    paddr,
  input  wire [gpm_pkg::APB_DW-1:0]    pwdata,
  output logic [gpm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import gpm_pkg::*;

  localparam int HIDX_W = (MAX_HOUSES > 1) ? $clog2(MAX_HOUSES) : 1;
  localparam int HCNT_W = $clog2(MAX_HOUSES + 1);
  localparam int SCNT_W = $clog2(MAX_SITES + 1);
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int EXT_W  = COORD_BITS + FIELD_W;
  localparam int KX_W   = K_W + 1;

  // control states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [HCNT_W-1:0]   house_cnt_r, house_cnt_nxt;
  logic [SCNT_W-1:0]   site_cnt_r, site_cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic                err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]  out_best_r, out_best_nxt;
  logic                out_err_r, out_err_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                accept, house_full, site_full, bad_req;
  logic                cfg_we, start;
  logic                house_we, site_we;
  logic [EXT_W-1:0]    row_ext, col_ext;
  logic [PT_W-1:0]     point;

  issue_ctl_t          iss;
  logic [HIDX_W-1:0]   iss_addr;
  logic [PT_W-1:0]     iss_site;
  logic                seq_busy, eng_busy;
  logic [TOTAL_W-1:0]  best;

  // one request at a time; loads finish in their accept cycle
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // low coordinate bits of the point
  assign row_ext = EXT_W'(in_row);
  assign col_ext = EXT_W'(in_col);
  assign point   = {row_ext[COORD_BITS-1:0], col_ext[COORD_BITS-1:0]};

  assign house_full = (house_cnt_r == HCNT_W'(MAX_HOUSES));
  assign site_full  = (site_cnt_r == SCNT_W'(MAX_SITES));
  assign house_we   = accept && (in_mode == MODE_ADD_HOUSE) && !house_full;
  assign site_we    = accept && (in_mode == MODE_ADD_SITE) && !site_full;

  // nothing to search: zero or too many sites to choose, or no houses
  assign bad_req = (k_r == '0) || (KX_W'(site_cnt_r) < KX_W'(k_r)) ||
                   (house_cnt_r == '0);
  assign start   = (state_r == ST_START) && !bad_req;

  // register port, always ready
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1:2] == REG_K_IDX);
  assign prdata = (paddr[APB_AW-1:2] == REG_K_IDX) ? APB_DW'(k_r) : '0;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = cfg_we ? pwdata[K_W-1:0] : k_r;
    house_cnt_nxt = house_cnt_r;
    site_cnt_nxt  = site_cnt_r;
    ovf_nxt       = ovf_r;
    err_nxt       = err_r;
    out_best_nxt  = out_best_r;
    out_err_nxt   = out_err_r;
    out_ovf_nxt   = out_ovf_r;
    // held result leaves when taken
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_ADD_HOUSE: begin
              if (house_full) ovf_nxt = 1'b1;
              else            house_cnt_nxt = house_cnt_r + 1'b1;
            end
            MODE_ADD_SITE: begin
              if (site_full) ovf_nxt = 1'b1;
              else           site_cnt_nxt = site_cnt_r + 1'b1;
            end
            MODE_COMPUTE: state_nxt = ST_START;
            MODE_CLEAR: begin
              house_cnt_nxt = '0;
              site_cnt_nxt  = '0;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_START: begin
        // error requests skip the search
        err_nxt   = bad_req;
        state_nxt = bad_req ? ST_EMIT : ST_WAIT;
      end
      ST_WAIT: begin
        // sequencer done issuing and last update retired
        if (!seq_busy && !eng_busy) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_best_nxt  = err_r ? '0 : best;
          out_err_nxt   = err_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= K_RESET;
      house_cnt_r <= '0;
      site_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      house_cnt_r <= house_cnt_nxt;
      site_cnt_r  <= site_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r      <= err_nxt;
    out_best_r <= out_best_nxt;
    out_err_r  <= out_err_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // subset walk and site store
  gpm_seq #(
    .MAX_HOUSES (MAX_HOUSES),
    .MAX_SITES  (MAX_SITES),
    .COORD_BITS (COORD_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .k           (k_r),
    .house_count (house_cnt_r),
    .site_count  (site_cnt_r),
    .site_we     (site_we),
    .site_wdata  (point),
    .iss         (iss),
    .iss_addr    (iss_addr),
    .iss_site    (iss_site),
    .busy        (seq_busy)
  );

  // house store, nearest-distance read-modify-write, best tracking
  gpm_eng #(
    .MAX_HOUSES (MAX_HOUSES),
    .COORD_BITS (COORD_BITS)
  ) u_eng (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear_best  (start),
    .house_we    (house_we),
    .house_waddr (house_cnt_r[HIDX_W-1:0]),
    .house_wdata (point),
    .iss         (iss),
    .iss_addr    (iss_addr),
    .iss_site    (iss_site),
    .busy        (eng_busy),
    .best        (best)
  );

  assign out_valid      = out_valid_r;
  assign out_best_total = out_best_r;
  assign out_error      = out_err_r;
  assign out_overflow   = out_ovf_r;

endmodule

`default_nettype wire

/* rtl/gpm_checker.sv */
// ----------------------------------------------------------------------------
// gpm_checker
// port-level checks of the site selector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire [gpm_pkg::MODE_W-1:0]    in_mode,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [gpm_pkg::TOTAL_W-1:0]   out_best_total,
  input wire                          out_error,
  input wire                          out_overflow
);
  import gpm_pkg::*;

  // held result stays put until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_total) &&
      $stable(out_error) && $stable(out_overflow))
    else $error("result changed while stalled");

  // error results carry a zero total
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_best_total == '0)
    else $error("error result with nonzero total");

  // a compute request closes the request channel
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_COMPUTE |=> !in_ready)
    else $error("request taken during compute");

  // a new result only appears at the end of a compute
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a compute");

  // reset empties the output
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_p_median_site_selector_unit gpm_checker u_gpm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_best_total (out_best_total),
  .out_error      (out_error),
  .out_overflow   (out_overflow)
);

`default_nettype wire
